[hw/rtl/cpf_pkg.sv]
// shared types and constants of the crc16 packet framer
package cpf_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int LEN_W       = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] START_BYTE_RESET = 8'h4A;
  localparam logic [7:0] END_BYTE_RESET   = 8'h4C;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_START_BYTE = 1'b0,
    REG_END_BYTE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             mode;
    logic [7:0]       frame_type;
    logic [7:0]       object_id;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
    logic       error;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_DATA,
    KIND_ERROR
  } cmd_kind_t;

  // one classified item, handed from front to back
  typedef struct packed {
    cmd_kind_t        kind;
    logic             trailer;
    logic [7:0]       frame_type;
    logic [7:0]       object_id;
    logic [LEN_W-1:0] length;
    logic [7:0]       data_byte;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  // byte position inside the burst of one command
  typedef enum logic [2:0] {
    STEP_FIRST,
    STEP_TYPE,
    STEP_ID,
    STEP_LEN_LO,
    STEP_LEN_HI,
    STEP_CRC_LO,
    STEP_CRC_HI,
    STEP_END
  } step_t;

endpackage

[hw/rtl/crc16_packet_framer.sv]
// top level of the crc16 packet framer
// Frame encoder with a CRC-16/MODBUS trailer (init 0xFFFF, reflected poly 0xA001).
// A start item (mode 0) yields the start byte, type, object id and the length
// (saturated to 1024, low byte first); when that length is zero the crc low,
// crc high and end byte follow at once. Each data item (mode 1) yields its byte,
// and the one that completes the frame adds the three trailer bytes. A data item
// with no open frame yields one result flagged error with byte 0. The front part
// takes one item per cycle into a four-entry command queue; the back part emits
// one byte per cycle while no result waits at the output, so throughput is set
// by the serializer: a data item yields one byte (four when it closes the frame),
// a start item five bytes (eight for an empty frame). Input stalls only when the
// queue is full. The output is a registered stage, held while its result waits.
// start_byte (index 0) and end_byte (index 1) are written through cfg_write;
// write them only while the block is idle.
module crc16_packet_framer import cpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration registers
  logic [7:0] start_byte;
  logic [7:0] end_byte;

  // front to queue
  logic          push;
  cmd_t          push_cmd;
  // queue to back
  queue_status_t q_status;
  cmd_t          head;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
      end_byte   <= END_BYTE_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default:        start_byte <= start_byte;
      endcase
    end
  end

  // classify each transfer and track frame open / bytes remaining
  cpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples item acceptance from byte emission
  cpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  // one byte per cycle while the output is not stalled, crc updated as bytes go out
  cpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head       (head),
    .pop        (pop),
    .start_byte (start_byte),
    .end_byte   (end_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[hw/rtl/cpf_front.sv]
// front end: accepts items, tracks the open frame and classifies each item
module cpf_front import cpf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  input  queue_status_t q_status,
  output logic          push,
  output cmd_t          push_cmd
);

  logic             frame_open, frame_open_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] rem_dec;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    len_sat = (in_data.payload_length > LEN_W'(MAX_PAYLOAD)) ?
              LEN_W'(MAX_PAYLOAD) : in_data.payload_length;
    rem_dec = (bytes_remaining != '0) ? bytes_remaining - LEN_W'(1) : '0;

    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;

    push_cmd.frame_type = in_data.frame_type;
    push_cmd.object_id  = in_data.object_id;
    push_cmd.length     = len_sat;
    push_cmd.data_byte  = in_data.data_byte;
    push_cmd.kind       = KIND_ERROR;
    push_cmd.trailer    = 1'b0;

    if (!in_data.mode) begin
      push_cmd.kind        = KIND_HEADER;
      push_cmd.trailer     = (len_sat == '0);
      frame_open_next      = (len_sat != '0);
      bytes_remaining_next = len_sat;
    end else if (frame_open) begin
      push_cmd.kind        = KIND_DATA;
      push_cmd.trailer     = (rem_dec == '0);
      frame_open_next      = (rem_dec != '0);
      bytes_remaining_next = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= '0;
    end else if (push) begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

[hw/rtl/cpf_queue.sv]
// short command queue between front and back
module cpf_queue import cpf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output queue_status_t q_status,
  output cmd_t          head
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign q_status.valid = (count != '0);
  assign q_status.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

endmodule

[hw/rtl/cpf_back.sv]
// back end: serializes commands into frame bytes and keeps the running crc
module cpf_back import cpf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_status,
  input  cmd_t          head,
  output logic          pop,
  input  logic [7:0]    start_byte,
  input  logic [7:0]    end_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  step_t       step, step_next;
  logic [15:0] crc, crc_next;
  logic        advance;
  logic        last;
  logic [7:0]  byte_sel;

  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign advance = q_status.valid && (!out_valid || out_ready);
  assign pop     = advance && last;

  always_comb begin
    last      = 1'b0;
    byte_sel  = 8'h00;
    step_next = step;
    crc_next  = crc;

    case (step)
      STEP_FIRST: begin
        case (head.kind)
          KIND_HEADER: byte_sel = start_byte;
          KIND_DATA:   byte_sel = head.data_byte;
          default:     byte_sel = 8'h00;
        endcase
        last = (head.kind == KIND_ERROR) || (head.kind == KIND_DATA && !head.trailer);
      end
      STEP_TYPE:   byte_sel = head.frame_type;
      STEP_ID:     byte_sel = head.object_id;
      STEP_LEN_LO: byte_sel = head.length[7:0];
      STEP_LEN_HI: begin
        byte_sel = {{(16 - LEN_W){1'b0}}, head.length[LEN_W-1:8]};
        last     = !head.trailer;
      end
      STEP_CRC_LO: byte_sel = crc[7:0];
      STEP_CRC_HI: byte_sel = crc[15:8];
      STEP_END: begin
        byte_sel = end_byte;
        last     = 1'b1;
      end
      default: byte_sel = 8'h00;
    endcase

    if (advance) begin
      if (last) begin
        step_next = STEP_FIRST;
      end else begin
        case (step)
          STEP_FIRST:  step_next = (head.kind == KIND_DATA) ? STEP_CRC_LO : STEP_TYPE;
          STEP_TYPE:   step_next = STEP_ID;
          STEP_ID:     step_next = STEP_LEN_LO;
          STEP_LEN_LO: step_next = STEP_LEN_HI;
          STEP_LEN_HI: step_next = STEP_CRC_LO;
          STEP_CRC_LO: step_next = STEP_CRC_HI;
          STEP_CRC_HI: step_next = STEP_END;
          default:     step_next = STEP_FIRST;
        endcase
      end

      case (step)
        STEP_FIRST: begin
          if (head.kind == KIND_HEADER) begin
            crc_next = CRC_INIT;
          end else if (head.kind == KIND_DATA) begin
            crc_next = crc_feed(crc, byte_sel);
          end
        end
        STEP_TYPE, STEP_ID, STEP_LEN_LO, STEP_LEN_HI: crc_next = crc_feed(crc, byte_sel);
        STEP_END: crc_next = CRC_INIT;
        default:  crc_next = crc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FIRST;
      crc  <= CRC_INIT;
    end else begin
      step <= step_next;
      crc  <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_byte   <= byte_sel;
      out_data.run_last   <= last;
      out_data.frame_done <= (step == STEP_END);
      out_data.error      <= (head.kind == KIND_ERROR);
    end
  end

endmodule

[hw/rtl/cpf_checker.sv]
// port-level checks of the crc16 packet framer, bound to the top level
module cpf_checker import cpf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |->
      out_data.run_last && !out_data.frame_done && (out_data.out_byte == 8'h00))
    else $error("error result malformed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.run_last && !out_data.error)
    else $error("end byte not last of its burst");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind crc16_packet_framer cpf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
